// File: design/gpn_pkg.sv
// Shared widths, controller states and command/status structs for the grid partition block.
package gpn_pkg;

    localparam int CNT_W  = 11;
    localparam int RANK_W = 10;
    localparam int SUM_W  = 13;
    localparam int STEP_W = 4;

    localparam logic [CNT_W-1:0] NBR_NONE = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TAG,
        S_A,
        S_AW,
        S_B,
        S_BW,
        S_PLANE,
        S_R1,
        S_R1W,
        S_R2,
        S_R2W,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_N_A,
        DIV_REST_B,
        DIV_R_GX,
        DIV_Q_GY
    } t_div_sel;

    typedef struct packed {
        logic     load_rank;
        logic     search_init;
        logic     div_start;
        t_div_sel div_sel;
        logic     a_next;
        logic     b_init;
        logic     b_test;
        logic     plane_calc;
        logic     save_q1;
        logic     save_cjck;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic tag_hit;
        logic n_small;
        logic a_done;
        logic divides;
        logic b_done;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// File: design/gpn_div.sv
// Restoring divider, one quotient bit per cycle.
module gpn_div import gpn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [CNT_W-1:0] o_quot,
    output logic [CNT_W-1:0] o_rem
);

    logic [CNT_W-1:0]  r_rem, r_quot, r_div;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [CNT_W:0]    n_shift;
    logic [CNT_W:0]    n_diff;

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
        n_shift = {r_rem, r_quot[CNT_W-1]};
        n_diff  = n_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(CNT_W - 1);
                r_rem  <= '0;
                r_quot <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (!n_diff[CNT_W]) begin
                    r_rem <= n_diff[CNT_W-1:0];
                end else begin
                    r_rem <= n_shift[CNT_W-1:0];
                end
                r_quot <= {r_quot[CNT_W-2:0], ~n_diff[CNT_W]};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// File: design/gpn_datapath.sv
// Datapath: count register, factor cache, search counters, rank split and result register.
module gpn_datapath import gpn_pkg::*; #(
    parameter logic [CNT_W-1:0] COUNT_LIMIT = 11'd1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    input  logic [RANK_W-1:0]        i_rank,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [CNT_W-1:0]         o_grid_x,
    output logic [CNT_W-1:0]         o_grid_y,
    output logic [CNT_W-1:0]         o_grid_z,
    output logic [RANK_W-1:0]        o_cell_i,
    output logic [RANK_W-1:0]        o_cell_j,
    output logic [RANK_W-1:0]        o_cell_k,
    output logic signed [CNT_W-1:0]  o_nbr_x_low,
    output logic signed [CNT_W-1:0]  o_nbr_x_high,
    output logic signed [CNT_W-1:0]  o_nbr_y_low,
    output logic signed [CNT_W-1:0]  o_nbr_y_high,
    output logic signed [CNT_W-1:0]  o_nbr_z_low,
    output logic signed [CNT_W-1:0]  o_nbr_z_high
);

    logic [CNT_W-1:0]  r_pcount, r_tag, r_gx, r_gy, r_gz, r_plane;
    logic [CNT_W-1:0]  r_a, r_b, r_rest, r_q1;
    logic [SUM_W-1:0]  r_best;
    logic [RANK_W-1:0] r_rank, r_ci, r_cj, r_ck;
    logic              r_out_valid;
    logic [CNT_W-1:0]  r_ox, r_oy, r_oz;
    logic [RANK_W-1:0] r_oi, r_oj, r_ok;
    logic [CNT_W-1:0]  r_n0, r_n1, r_n2, r_n3, r_n4, r_n5;

    logic [CNT_W-1:0]     n_eff, n_dvd, n_dvs, n_quot, n_rem, n_rank11;
    logic [SUM_W-1:0]     n_sum;
    logic [2*CNT_W-1:0]   n_prod;
    logic                 n_done, n_in_range;

    // Saturate the configured count at the limit.
    assign n_eff = (r_pcount > COUNT_LIMIT) ? COUNT_LIMIT : r_pcount;

    // Operand selection for the shared divider.
    always_comb begin
        case (i_cmd.div_sel)
            DIV_N_A:    begin n_dvd = n_eff;             n_dvs = r_a;  end
            DIV_REST_B: begin n_dvd = r_rest;            n_dvs = r_b;  end
            DIV_R_GX:   begin n_dvd = {1'b0, r_rank};    n_dvs = r_gx; end
            DIV_Q_GY:   begin n_dvd = r_q1;              n_dvs = r_gy; end
            default:    begin n_dvd = r_q1;              n_dvs = r_gy; end
        endcase
    end

    gpn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_done     (n_done),
        .o_quot     (n_quot),
        .o_rem      (n_rem)
    );

    assign n_sum    = SUM_W'(r_a) + SUM_W'(r_b) + SUM_W'(n_quot);
    assign n_prod   = r_gx * r_gy;
    assign n_rank11 = {1'b0, r_rank};
    assign n_in_range = n_rank11 < n_eff;

    // Status back to the controller.
    always_comb begin
        o_stat.tag_hit  = (r_tag == n_eff);
        o_stat.n_small  = (n_eff <= CNT_W'(1));
        o_stat.a_done   = (r_a > (n_eff >> 1));
        o_stat.divides  = (n_rem == '0);
        o_stat.b_done   = (r_b > (r_rest >> 1));
        o_stat.div_done = n_done;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // Configuration, factor cache and search state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= CNT_W'(1);
            r_tag    <= '0;
            r_gx     <= CNT_W'(1);
            r_gy     <= CNT_W'(1);
            r_gz     <= CNT_W'(1);
            r_plane  <= CNT_W'(1);
        end else begin
            if (i_cfg_we) begin
                r_pcount <= i_cfg_wdata;
            end
            if (i_cmd.search_init) begin
                r_tag  <= n_eff;
                r_gx   <= CNT_W'(1);
                r_gy   <= CNT_W'(1);
                r_gz   <= CNT_W'(1);
                r_a    <= CNT_W'(1);
                r_best <= SUM_W'(n_eff) + SUM_W'(3);
            end
            if (i_cmd.a_next) begin
                r_a <= r_a + 1'b1;
            end
            if (i_cmd.b_init) begin
                r_rest <= n_quot;
                r_b    <= CNT_W'(1);
            end
            // Keep the first strict minimum of the sum.
            if (i_cmd.b_test) begin
                r_b <= r_b + 1'b1;
                if (n_rem == '0 && n_sum < r_best) begin
                    r_best <= n_sum;
                    r_gx   <= r_a;
                    r_gy   <= r_b;
                    r_gz   <= n_quot;
                end
            end
            if (i_cmd.plane_calc) begin
                r_plane <= n_prod[CNT_W-1:0];
            end
        end
    end

    // Rank split into cell coordinates.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rank) begin
            r_rank <= i_rank;
        end
        if (i_cmd.save_q1) begin
            r_ci <= n_rem[RANK_W-1:0];
            r_q1 <= n_quot;
        end
        if (i_cmd.save_cjck) begin
            r_cj <= n_rem[RANK_W-1:0];
            r_ck <= n_quot[RANK_W-1:0];
        end
    end

    // Result register and its valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ox <= r_gx;
            r_oy <= r_gy;
            r_oz <= r_gz;
            r_oi <= '0;
            r_oj <= '0;
            r_ok <= '0;
            r_n0 <= NBR_NONE;
            r_n1 <= NBR_NONE;
            r_n2 <= NBR_NONE;
            r_n3 <= NBR_NONE;
            r_n4 <= NBR_NONE;
            r_n5 <= NBR_NONE;
            if (n_in_range) begin
                r_oi <= r_ci;
                r_oj <= r_cj;
                r_ok <= r_ck;
                if (r_ci != '0)                      r_n0 <= n_rank11 - 1'b1;
                if (({1'b0, r_ci} + 1'b1) < r_gx)    r_n1 <= n_rank11 + 1'b1;
                if (r_cj != '0)                      r_n2 <= n_rank11 - r_gx;
                if (({1'b0, r_cj} + 1'b1) < r_gy)    r_n3 <= n_rank11 + r_gx;
                if (r_ck != '0)                      r_n4 <= n_rank11 - r_plane;
                if (({1'b0, r_ck} + 1'b1) < r_gz)    r_n5 <= n_rank11 + r_plane;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_grid_x     = r_ox;
    assign o_grid_y     = r_oy;
    assign o_grid_z     = r_oz;
    assign o_cell_i     = r_oi;
    assign o_cell_j     = r_oj;
    assign o_cell_k     = r_ok;
    assign o_nbr_x_low  = $signed(r_n0);
    assign o_nbr_x_high = $signed(r_n1);
    assign o_nbr_y_low  = $signed(r_n2);
    assign o_nbr_y_high = $signed(r_n3);
    assign o_nbr_z_low  = $signed(r_n4);
    assign o_nbr_z_high = $signed(r_n5);

endmodule

// File: design/gpn_ctrl.sv
// Controller: sequences the factor search and the rank split over the shared divider.
module gpn_ctrl import gpn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_rank = 1'b1;
                    n_state = S_TAG;
                end
            end
            S_TAG: begin
                if (i_stat.tag_hit) begin
                    n_state = S_R1;
                end else begin
                    o_cmd.search_init = 1'b1;
                    n_state = i_stat.n_small ? S_PLANE : S_A;
                end
            end
            S_A: begin
                if (i_stat.a_done) begin
                    n_state = S_PLANE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_N_A;
                    n_state = S_AW;
                end
            end
            S_AW: begin
                if (i_stat.div_done) begin
                    if (i_stat.divides) begin
                        o_cmd.b_init = 1'b1;
                        n_state = S_B;
                    end else begin
                        o_cmd.a_next = 1'b1;
                        n_state = S_A;
                    end
                end
            end
            S_B: begin
                if (i_stat.b_done) begin
                    o_cmd.a_next = 1'b1;
                    n_state = S_A;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_REST_B;
                    n_state = S_BW;
                end
            end
            S_BW: begin
                if (i_stat.div_done) begin
                    o_cmd.b_test = 1'b1;
                    n_state = S_B;
                end
            end
            S_PLANE: begin
                o_cmd.plane_calc = 1'b1;
                n_state = S_R1;
            end
            S_R1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_R_GX;
                n_state = S_R1W;
            end
            S_R1W: begin
                if (i_stat.div_done) begin
                    o_cmd.save_q1 = 1'b1;
                    n_state = S_R2;
                end
            end
            S_R2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_Q_GY;
                n_state = S_R2W;
            end
            S_R2W: begin
                if (i_stat.div_done) begin
                    o_cmd.save_cjck = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/grid_partition_neighbors.sv
// Top level of the 3D grid partition and face-neighbor block.
// The block takes one rank at a time. With the factors cached, a rank runs
// the tag check, two 11-step passes of the shared restoring divider (rank by
// grid_x, then that quotient by grid_y), each with its start and done states,
// and the result load. After partition_count changes, the first rank also
// runs the factor search on the same divider, with roughly N/2 outer and the
// sum of rest/2 inner trial divisions. The result register holds a finished
// result while it waits to be taken.
module grid_partition_neighbors import gpn_pkg::*; #(
    parameter int MAX_PARTITIONS = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CNT_W-1:0]         i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [RANK_W-1:0]        i_rank,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [CNT_W-1:0]         o_grid_x,
    output logic [CNT_W-1:0]         o_grid_y,
    output logic [CNT_W-1:0]         o_grid_z,
    output logic [RANK_W-1:0]        o_cell_i,
    output logic [RANK_W-1:0]        o_cell_j,
    output logic [RANK_W-1:0]        o_cell_k,
    output logic signed [CNT_W-1:0]  o_nbr_x_low,
    output logic signed [CNT_W-1:0]  o_nbr_x_high,
    output logic signed [CNT_W-1:0]  o_nbr_y_low,
    output logic signed [CNT_W-1:0]  o_nbr_y_high,
    output logic signed [CNT_W-1:0]  o_nbr_z_low,
    output logic signed [CNT_W-1:0]  o_nbr_z_high
);

    // A limit above the register's range is clipped to the register maximum.
    localparam int CountMax = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] COUNT_LIMIT =
        CNT_W'((MAX_PARTITIONS > CountMax) ? CountMax : MAX_PARTITIONS);

    t_cmd  w_cmd;
    t_stat w_stat;

    gpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gpn_datapath #(.COUNT_LIMIT(COUNT_LIMIT)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_rank       (i_rank),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_grid_x     (o_grid_x),
        .o_grid_y     (o_grid_y),
        .o_grid_z     (o_grid_z),
        .o_cell_i     (o_cell_i),
        .o_cell_j     (o_cell_j),
        .o_cell_k     (o_cell_k),
        .o_nbr_x_low  (o_nbr_x_low),
        .o_nbr_x_high (o_nbr_x_high),
        .o_nbr_y_low  (o_nbr_y_low),
        .o_nbr_y_high (o_nbr_y_high),
        .o_nbr_z_low  (o_nbr_z_low),
        .o_nbr_z_high (o_nbr_z_high)
    );

`ifndef ASSERT_OFF
    // A result never shows an empty grid dimension.
    a_grid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_grid_x != '0 && o_grid_y != '0 && o_grid_z != '0))
        else $error("grid dimension of zero in a result");

    // An upper x neighbor exists only inside the grid along x.
    a_xhigh_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_nbr_x_high != $signed(NBR_NONE))
            |-> (({1'b0, o_cell_i} + 1'b1) < o_grid_x))
        else $error("upper x neighbor at the grid boundary");

    // A lower z neighbor exists only above the bottom plane.
    a_zlow_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_nbr_z_low != $signed(NBR_NONE)) |-> (o_cell_k != '0))
        else $error("lower z neighbor on the bottom plane");

    // Two results are never loaded back to back.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> !w_cmd.out_load)
        else $error("two results loaded in consecutive cycles");
`endif

endmodule

// File: tb/grid_partition_neighbors_tb.sv
// Self-checking testbench for the grid partition and face-neighbor block.
`timescale 1ns / 100ps

module grid_partition_neighbors_tb;
    import gpn_pkg::*;

    localparam int MAX_PARTS = 1024;

    // One expected result of a rank lookup.
    typedef struct {
        logic [CNT_W-1:0]  gx, gy, gz;
        logic [RANK_W-1:0] ci, cj, ck;
        logic [CNT_W-1:0]  nb [6];
    } t_placement;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [RANK_W-1:0] i_rank = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [CNT_W-1:0]  o_grid_x, o_grid_y, o_grid_z;
    logic [RANK_W-1:0] o_cell_i, o_cell_j, o_cell_k;
    logic signed [CNT_W-1:0] o_nbr_x_low, o_nbr_x_high, o_nbr_y_low;
    logic signed [CNT_W-1:0] o_nbr_y_high, o_nbr_z_low, o_nbr_z_high;

    grid_partition_neighbors #(.MAX_PARTITIONS(MAX_PARTS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_rank(i_rank),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_grid_x(o_grid_x), .o_grid_y(o_grid_y), .o_grid_z(o_grid_z),
        .o_cell_i(o_cell_i), .o_cell_j(o_cell_j), .o_cell_k(o_cell_k),
        .o_nbr_x_low(o_nbr_x_low), .o_nbr_x_high(o_nbr_x_high),
        .o_nbr_y_low(o_nbr_y_low), .o_nbr_y_high(o_nbr_y_high),
        .o_nbr_z_low(o_nbr_z_low), .o_nbr_z_high(o_nbr_z_high)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: the count register and the cached factorization.
    int unsigned part_count = 1;
    int unsigned dims_x = 1, dims_y = 1, dims_z = 1;
    int unsigned dims_for = 0;

    logic [RANK_W-1:0] pending_ranks [$];
    t_placement        expected_places [$];
    int  send_idle_pct = 0, recv_idle_pct = 0;
    bit  recv_hold = 1'b0;
    int  error_count = 0, results_seen = 0, counts_used = 0;
    event stall_start;

    // Least-sum factorization, first strict minimum kept.
    function automatic void factor_grid(input int unsigned n);
        int unsigned best, rest, c;
        best = n + 3;
        dims_x = 1; dims_y = 1; dims_z = 1;
        if (n > 1) begin
            for (int unsigned a = 1; a <= n / 2; a++) begin
                if (n % a != 0) continue;
                rest = n / a;
                for (int unsigned b = 1; b <= rest / 2; b++) begin
                    if (rest % b != 0) continue;
                    c = rest / b;
                    if (a + b + c < best) begin
                        best = a + b + c;
                        dims_x = a; dims_y = b; dims_z = c;
                    end
                end
            end
        end
    endfunction

    // Expected placement of one rank under the current count.
    function automatic t_placement place_rank(input int unsigned r);
        t_placement p;
        int unsigned n, plane, ci, cj, ck;
        n = (part_count > MAX_PARTS) ? MAX_PARTS : part_count;
        if (dims_for != n) begin
            factor_grid(n);
            dims_for = n;
        end
        plane = dims_x * dims_y;
        p.gx = CNT_W'(dims_x); p.gy = CNT_W'(dims_y); p.gz = CNT_W'(dims_z);
        p.ci = '0; p.cj = '0; p.ck = '0;
        foreach (p.nb[t]) p.nb[t] = NBR_NONE;
        if (r < n) begin
            ci = r % dims_x;
            cj = (r / dims_x) % dims_y;
            ck = r / plane;
            p.ci = RANK_W'(ci); p.cj = RANK_W'(cj); p.ck = RANK_W'(ck);
            if (ci > 0) p.nb[0] = CNT_W'(r - 1);
            if (ci + 1 < dims_x) p.nb[1] = CNT_W'(r + 1);
            if (cj > 0) p.nb[2] = CNT_W'(r - dims_x);
            if (cj + 1 < dims_y) p.nb[3] = CNT_W'(r + dims_x);
            if (ck > 0) p.nb[4] = CNT_W'(r - plane);
            if (ck + 1 < dims_z) p.nb[5] = CNT_W'(r + plane);
        end
        return p;
    endfunction

    logic in_xfer;
    always @(posedge i_clk) in_xfer <= i_in_valid && o_in_ready && i_rst_n;

    // Driver: offer queued ranks, idling at random between transfers.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_xfer) begin
            if (pending_ranks.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                i_rank <= pending_ranks.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long receiver stall, counted here while the sender keeps offering.
    initial begin
        forever begin
            @(stall_start);
            recv_hold = 1'b1;
            repeat (400) @(posedge i_clk);
            recv_hold = 1'b0;
        end
    end

    // Monitor: predict on input transfers, check on output transfers.
    always @(posedge i_clk) begin
        t_placement e;
        logic [CNT_W-1:0] got [6];
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_places.push_back(place_rank(i_rank));
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            got = '{o_nbr_x_low, o_nbr_x_high, o_nbr_y_low,
                    o_nbr_y_high, o_nbr_z_low, o_nbr_z_high};
            if (expected_places.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, none expected", $realtime);
            end else begin
                e = expected_places.pop_front();
                if ({o_grid_x, o_grid_y, o_grid_z} != {e.gx, e.gy, e.gz}) begin
                    error_count++;
                    $display("%0t: grid exp %0d,%0d,%0d got %0d,%0d,%0d", $realtime,
                             e.gx, e.gy, e.gz, o_grid_x, o_grid_y, o_grid_z);
                end
                if ({o_cell_i, o_cell_j, o_cell_k} != {e.ci, e.cj, e.ck}) begin
                    error_count++;
                    $display("%0t: cell exp %0d,%0d,%0d got %0d,%0d,%0d", $realtime,
                             e.ci, e.cj, e.ck, o_cell_i, o_cell_j, o_cell_k);
                end
                foreach (got[t]) begin
                    if (got[t] !== e.nb[t]) begin
                        error_count++;
                        $display("%0t: neighbor %0d exp %h got %h", $realtime,
                                 t, e.nb[t], got[t]);
                    end
                end
            end
        end
    end

    // Wait until every queued rank is taken and every result checked.
    task automatic drain();
        while (pending_ranks.size() != 0 || i_in_valid || expected_places.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Register write while idle; the predictor follows once the write strobe is dropped.
    task automatic write_count(input int unsigned n);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= CNT_W'(n);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        part_count = n;
        counts_used++;
    endtask

    // Random ranks, mostly inside the grid, some beyond the count.
    task automatic queue_ranks(input int unsigned n, input int num);
        int unsigned lim;
        lim = (n > MAX_PARTS) ? MAX_PARTS : n;
        repeat (num) begin
            if (lim != 0 && $urandom_range(9) < 8)
                pending_ranks.push_back(RANK_W'($urandom_range(lim - 1)));
            else
                pending_ranks.push_back(RANK_W'($urandom));
        end
    endtask

    initial begin
        int unsigned directed_counts [] = '{0, 1, 2, 7, 12, 64, 1024, 2047, 1000};
        int unsigned n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset count, then edge counts with corner ranks.
        pending_ranks.push_back(10'd0);
        pending_ranks.push_back(10'd1023);
        drain();
        foreach (directed_counts[c]) begin
            write_count(directed_counts[c]);
            pending_ranks.push_back(10'd0);
            pending_ranks.push_back(10'd1023);
            if (directed_counts[c] > 1)
                pending_ranks.push_back(directed_counts[c] > 1024 ?
                                        10'd512 : RANK_W'(directed_counts[c] - 1));
            drain();
        end

        // Random phases across three idling profiles.
        for (int ph = 0; ph < 36; ph++) begin
            send_idle_pct = (ph < 12) ? 11 : (ph < 24) ? 46 : 0;
            recv_idle_pct = (ph < 12) ? 46 : (ph < 24) ? 11 : 0;
            case ($urandom_range(3))
                0: n = $urandom_range(1, 64);
                1: n = $urandom_range(65, 300);
                2: n = $urandom_range(2047);
                default: n = $urandom_range(1, 1024);
            endcase
            write_count(n);
            if (ph == 30) begin
                // Long receiver stall while the sender keeps offering.
                -> stall_start;
            end
            queue_ranks(n, 50);
            drain();
        end

        $display("Checked %0d results over %0d count settings.", results_seen, counts_used);
        $display("Covered sender and receiver idling, a long stall and out-of-range ranks.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end
endmodule

// File: grid_partition_neighbors.f
design/gpn_pkg.sv
design/gpn_div.sv
design/gpn_datapath.sv
design/gpn_ctrl.sv
design/grid_partition_neighbors.sv
tb/grid_partition_neighbors_tb.sv
